/* rtl/core/bra_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// bitmap run allocator. No dependencies.
package bra_pkg;

  localparam int MAX_CHUNKS = 4096;
  localparam int WORD_W     = 32;
  localparam int MAP_DEPTH  = MAX_CHUNKS / WORD_W;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int CHUNK_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 13;
  localparam int TDATA_W    = 32;

  localparam logic [COUNT_W-1:0] CHUNK_TOTAL_RST = 13'd4096;
  localparam logic [CHUNK_W-1:0] FIRST_CHUNK_RST = 12'd1;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_ALLOC   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FREED   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_CHUNK_TOTAL = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FIRST_CHUNK = 1'b1;

  typedef struct packed {
    logic                clr;        // zero one map word, advance
    logic                load_free;  // capture a free transaction
    logic                load_alloc; // capture an allocate transaction
    logic                rd;         // read map word at current address
    logic                free_wr;    // clear range bits in current word
    logic                srch;       // look for first free chunk, mark on hit
    logic                mark;       // extend run into current word
    logic                fin;        // load result register
    logic [STATUS_W-1:0] fin_code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic free_none;
    logic free_last;
    logic found;
    logic srch_last;
    logic mark_cont;
  } dp_sts_t;

endpackage

/* rtl/core/bra_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/bra_ctrl.sv */
// Controller state machine for the bitmap run allocator: sequences map
// clearing, free and allocate word walks, and the result handshake. Uses bra_pkg.
module bra_ctrl import bra_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_kind,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_FREE_RD = 4'd2;
  localparam logic [3:0] S_FREE_WR = 4'd3;
  localparam logic [3:0] S_SRCH_RD = 4'd4;
  localparam logic [3:0] S_SRCH    = 4'd5;
  localparam logic [3:0] S_MARK_RD = 4'd6;
  localparam logic [3:0] S_MARK    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;
  logic                out_vld_r, out_vld_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  always_comb begin
    state_nxt   = state_r;
    code_nxt    = code_r;
    out_vld_nxt = out_vld_r && !out_tready;
    cmd         = '0;
    cmd.fin_code = code_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_kind == REQ_FREE) begin
            cmd.load_free = 1'b1;
            code_nxt      = STS_FREED;
            state_nxt     = sts.free_none ? S_DONE : S_FREE_RD;
          end else begin
            cmd.load_alloc = 1'b1;
            state_nxt      = S_SRCH_RD;
          end
        end
      end
      S_FREE_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = sts.free_last ? S_DONE : S_FREE_RD;
      end
      S_SRCH_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (sts.found) begin
          code_nxt  = STS_ALLOC;
          state_nxt = sts.mark_cont ? S_MARK_RD : S_DONE;
        end else if (sts.srch_last) begin
          code_nxt  = STS_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_MARK_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = sts.mark_cont ? S_MARK_RD : S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free or being emptied
        if (!out_vld_r || out_tready) begin
          cmd.fin     = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      code_r    <= STS_FREED;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      code_r    <= code_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (state_r != S_CLEAR))
    else $error("map clear pass re-entered without reset");

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_vld_r)
    else $error("result loaded but not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_free || cmd.load_alloc) |=> !in_tready)
    else $error("second transaction taken while one is in progress");

endmodule

/* rtl/core/bra_dp.sv */
// Datapath of the bitmap run allocator: configuration registers, usage map
// RAM (bra_ram), word masks, first-free search, run marking, result register.
// Uses bra_pkg.
module bra_dp import bra_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic [CHUNK_W-1:0]  in_start,
  input  logic [COUNT_W-1:0]  in_count,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic [CHUNK_W-1:0]  res_start,
  output logic [COUNT_W-1:0]  res_count,
  output logic [STATUS_W-1:0] res_status
);

  // bits of word addr whose chunk index lies in [lo, hi)
  function automatic logic [WORD_W-1:0] word_mask(input logic [MAP_AW-1:0] addr,
                                                  input logic [COUNT_W:0] lo,
                                                  input logic [COUNT_W:0] hi);
    logic [WORD_W-1:0] m;
    logic [COUNT_W:0]  idx;
    for (int b = 0; b < WORD_W; b++) begin
      idx  = {2'b00, addr, BIT_W'(b)};
      m[b] = (idx >= lo) && (idx < hi);
    end
    return m;
  endfunction

  logic [COUNT_W-1:0] chunk_total_r;
  logic [CHUNK_W-1:0] first_chunk_r;
  logic [MAP_AW-1:0]  waddr_r;
  logic [CHUNK_W-1:0] start_r;
  logic [COUNT_W-1:0] end_r;
  logic [COUNT_W-1:0] want_r;
  logic [CHUNK_W-1:0] gstart_r;
  logic [COUNT_W-1:0] gcount_r;
  logic [CHUNK_W-1:0] res_start_r;
  logic [COUNT_W-1:0] res_count_r;
  logic [STATUS_W-1:0] res_status_r;

  logic [COUNT_W-1:0] limit;
  logic [COUNT_W:0]   sum_in, end_in, base_next;
  logic [WORD_W-1:0]  rdata, wdata, avail, free_in, shifted, set_mask;
  logic               wr_en;
  logic [BIT_W-1:0]   ffs, p;
  logic [BIT_W:0]     run, take;
  logic [BIT_W+1:0]   hi_bit;

  assign limit = (chunk_total_r > COUNT_W'(MAX_CHUNKS)) ? COUNT_W'(MAX_CHUNKS) : chunk_total_r;

  assign sum_in    = {2'b00, in_start} + {1'b0, in_count};
  assign end_in    = (sum_in > {1'b0, limit}) ? {1'b0, limit} : sum_in;
  assign base_next = {2'b00, waddr_r, BIT_W'(0)} + (COUNT_W+1)'(WORD_W);

  // search window and free chunks below the limit
  assign avail   = ~rdata & word_mask(waddr_r, {2'b00, first_chunk_r}, {1'b0, limit});
  assign free_in = ~rdata & word_mask(waddr_r, '0, {1'b0, limit});

  always_comb begin
    ffs = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) ffs = BIT_W'(b);
    end
  end

  // run starts at the first free bit on a search hit, else at bit 0
  assign p       = cmd.srch ? ffs : '0;
  assign shifted = free_in >> p;

  always_comb begin
    run = (BIT_W+1)'(WORD_W);
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!shifted[b]) run = (BIT_W+1)'(b);
    end
  end

  assign take   = (want_r < {{(COUNT_W-BIT_W-1){1'b0}}, run}) ? want_r[BIT_W:0] : run;
  assign hi_bit = {2'b00, p} + {1'b0, take};

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      set_mask[b] = ((BIT_W+2)'(b) >= {2'b00, p}) && ((BIT_W+2)'(b) < hi_bit);
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wdata = rdata;
    if (cmd.clr) begin
      wr_en = 1'b1;
      wdata = '0;
    end else if (cmd.free_wr) begin
      wr_en = 1'b1;
      wdata = rdata & ~word_mask(waddr_r, {2'b00, start_r}, {1'b0, end_r});
    end else if (cmd.mark || (cmd.srch && sts.found)) begin
      wr_en = 1'b1;
      wdata = rdata | set_mask;
    end
  end

  assign sts.clr_last  = (waddr_r == MAP_AW'(MAP_DEPTH - 1));
  assign sts.free_none = ({2'b00, in_start} >= end_in);
  assign sts.free_last = (base_next >= {1'b0, end_r});
  assign sts.found     = |avail;
  assign sts.srch_last = (base_next >= {1'b0, limit});
  // keep marking only if the run fills the word, more is wanted, and space remains
  assign sts.mark_cont = (take == ((BIT_W+1)'(WORD_W) - {1'b0, p}))
                      && (want_r != {{(COUNT_W-BIT_W-1){1'b0}}, take})
                      && (base_next < {1'b0, limit});

  bra_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(waddr_r),
    .wr_data(wdata),
    .rd_en  (cmd.rd),
    .rd_addr(waddr_r),
    .rd_data(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_total_r <= CHUNK_TOTAL_RST;
      first_chunk_r <= FIRST_CHUNK_RST;
      waddr_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_CHUNK_TOTAL: chunk_total_r <= cfg_wdata;
          CFG_FIRST_CHUNK: first_chunk_r <= cfg_wdata[CHUNK_W-1:0];
          default: ;
        endcase
      end
      priority if (cmd.load_free) begin
        waddr_r <= in_start[CHUNK_W-1:BIT_W];
      end else if (cmd.load_alloc) begin
        waddr_r <= first_chunk_r[CHUNK_W-1:BIT_W];
      end else if (cmd.clr || cmd.free_wr || cmd.mark
                   || (cmd.srch && (sts.found ? sts.mark_cont : 1'b1))) begin
        waddr_r <= waddr_r + 1'b1;
      end else begin
        waddr_r <= waddr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_free) begin
      start_r <= in_start;
      end_r   <= end_in[COUNT_W-1:0];
    end
    if (cmd.load_alloc) begin
      want_r   <= (in_count == '0) ? COUNT_W'(1) : in_count;
      gcount_r <= '0;
    end else if (cmd.mark || (cmd.srch && sts.found)) begin
      want_r   <= want_r - {{(COUNT_W-BIT_W-1){1'b0}}, take};
      gcount_r <= gcount_r + {{(COUNT_W-BIT_W-1){1'b0}}, take};
    end
    if (cmd.srch && sts.found) begin
      gstart_r <= {waddr_r, ffs};
    end
    if (cmd.fin) begin
      res_status_r <= cmd.fin_code;
      res_start_r  <= (cmd.fin_code == STS_ALLOC) ? gstart_r : '0;
      res_count_r  <= (cmd.fin_code == STS_ALLOC) ? gcount_r : '0;
    end
  end

  assign res_start  = res_start_r;
  assign res_count  = res_count_r;
  assign res_status = res_status_r;

  a_free_clears_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_wr |-> ((wdata & ~rdata) == '0))
    else $error("free transaction set a map bit");

  a_mark_sets_only: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mark || cmd.srch) |-> ((rdata & ~wdata) == '0))
    else $error("allocate transaction cleared a map bit");

  a_hit_takes_one: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.srch && sts.found) |-> (take != '0))
    else $error("search hit marked no chunk");

endmodule

/* rtl/core/bitmap_run_allocator_core.sv */
// First-fit bitmap run allocator over a one-bit-per-chunk usage map.
//
// Input channel (in_*): one transaction per request. in_tuser is the request
// kind (0 allocate, 1 free); in_tdata carries run_start and run_count.
// Output channel (out_*): exactly one result transaction per request.
// out_tuser is the status (0 allocated, 1 no free chunk, 2 range freed);
// out_tdata carries granted_start and granted_count.
// Configuration (cfg_*): index 0 chunk_total, index 1 first_storage_chunk;
// write only while no request is in flight.
//
// The map lives in a 128 x 32 RAM and every request walks it one word at a
// time: a registered read, then modify and write. One request is in flight
// at a time. After reset a pass zeroes the map; in_tready stays low meanwhile.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, a second result waits until the first leaves.
module bitmap_run_allocator_core import bra_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [TDATA_W-1:0]  in_tdata,   // [11:0] run_start, [24:12] run_count
  input  logic                in_tuser,   // [0] req_type
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [TDATA_W-1:0]  out_tdata,  // [11:0] granted_start, [24:12] granted_count
  output logic [STATUS_W-1:0] out_tuser   // [1:0] status
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [CHUNK_W-1:0] res_start;
  logic [COUNT_W-1:0] res_count;

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_start  (in_tdata[CHUNK_W-1:0]),
    .in_count  (in_tdata[CHUNK_W+COUNT_W-1:CHUNK_W]),
    .cmd       (cmd),
    .sts       (sts),
    .res_start (res_start),
    .res_count (res_count),
    .res_status(out_tuser)
  );

  assign out_tdata = {{(TDATA_W-CHUNK_W-COUNT_W){1'b0}}, res_count, res_start};

endmodule

/* bench/tb.sv */
// Self-checking bench for bitmap_run_allocator_core: drives allocate/free
// requests, predicts every grant from its own copy of the usage map and
// compares each result transaction. Depends on bra_pkg and the core RTL.
module tb;
  import bra_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_500_000;
  localparam int unsigned DRAIN_TAIL     = 300;
  localparam int unsigned RX_HOLD_CYCLES = 2000;

  typedef struct packed {
    logic [CHUNK_W-1:0]  start;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } grant_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } run_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = CFG_CHUNK_TOTAL;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata = '0;   // [11:0] run_start, [24:12] run_count
  logic                in_tuser = REQ_ALLOC;  // [0] req_type
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;       // [11:0] granted_start, [24:12] granted_count
  logic [STATUS_W-1:0] out_tuser;       // [1:0] status

  // shadow of the allocator state
  bit [MAX_CHUNKS-1:0] chunk_used = '0;
  int unsigned         shadow_total = 32'(CHUNK_TOTAL_RST);
  int unsigned         shadow_first = 32'(FIRST_CHUNK_RST);

  grant_t      grant_q[$];
  run_t        live_runs[$];
  grant_t      rsp_exp;
  grant_t      rsp_got;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  bit          tx_gapless = 1'b0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;

  bitmap_run_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Apply the request to the shadow map and return the grant it yields.
  function automatic grant_t predict_grant(input logic kind, input int unsigned start,
                                           input int unsigned count);
    grant_t      g;
    int unsigned limit;
    int unsigned stop;
    int unsigned want;
    int unsigned i;
    int unsigned n;
    run_t        r;
    g = '0;
    limit = (shadow_total > MAX_CHUNKS) ? MAX_CHUNKS : shadow_total;
    if (kind == REQ_FREE) begin
      stop = start + count;
      if (stop > limit) stop = limit;
      for (i = start; i < stop; i++) chunk_used[i] = 1'b0;
      g.status = STS_FREED;
    end else begin
      want = (count == 0) ? 1 : count;
      i = shadow_first;
      while (i < limit && chunk_used[i]) i++;
      if (i < limit) begin
        g.start = CHUNK_W'(i);
        n = 0;
        while (i < limit && n < want && !chunk_used[i]) begin
          chunk_used[i] = 1'b1;
          n++;
          i++;
        end
        g.count = COUNT_W'(n);
        g.status = STS_ALLOC;
        r.start = g.start;
        r.count = g.count;
        live_runs.push_back(r);
      end else begin
        g.status = STS_NOSPACE;
      end
    end
    return g;
  endfunction

  function automatic void note_mismatch(input string what, input grant_t exp_g,
                                        input grant_t got_g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0d] %s: expected start=%0d count=%0d status=%0d",
               cycle_count, what, exp_g.start, exp_g.count, exp_g.status);
      $display("[%0d] %s: got      start=%0d count=%0d status=%0d",
               cycle_count, what, got_g.start, got_g.count, got_g.status);
    end
  endfunction

  // Receiver: long hold-off when asked, otherwise a changing stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (cycle_count % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rsp_got = {out_tdata[CHUNK_W-1:0], out_tdata[CHUNK_W+COUNT_W-1:CHUNK_W], out_tuser};
      if (grant_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0, rsp_got);
      end else begin
        rsp_exp = grant_q.pop_front();
        if (rsp_got.start !== rsp_exp.start || rsp_got.count !== rsp_exp.count ||
            rsp_got.status !== rsp_exp.status)
          note_mismatch("grant mismatch", rsp_exp, rsp_got);
      end
    end
  end

  task automatic send_req(input logic kind, input int unsigned start,
                          input int unsigned count);
    int unsigned        gap;
    logic [CHUNK_W-1:0] start_f;
    logic [COUNT_W-1:0] count_f;
    start_f = CHUNK_W'(start);
    count_f = COUNT_W'(count);
    grant_q.push_back(predict_grant(kind, 32'(start_f), 32'(count_f)));
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(TDATA_W-CHUNK_W-COUNT_W){1'b0}}, count_f, start_f};
    do @(posedge clk); while (!in_tready);
    if (!tx_gapless) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Hold the sender until every pending grant has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (grant_q.size() != 0);
  endtask

  task automatic set_config(input int unsigned total, input int unsigned first);
    logic [CFG_DW-1:0]  total_f;
    logic [CHUNK_W-1:0] first_f;
    total_f = CFG_DW'(total);
    first_f = CHUNK_W'(first);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CHUNK_TOTAL;
    cfg_wdata <= total_f;
    @(posedge clk);
    cfg_addr  <= CFG_FIRST_CHUNK;
    cfg_wdata <= {{(CFG_DW-CHUNK_W){1'b0}}, first_f};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    shadow_total = 32'(total_f);
    shadow_first = 32'(first_f);
  endtask

  task automatic test_reset_defaults();
    send_req(REQ_ALLOC, 0, 0);          // zero count acts as one
    send_req(REQ_ALLOC, 4095, 4096);    // runs to the chunk count
    send_req(REQ_ALLOC, 0, 5);          // map full
    send_req(REQ_FREE, 0, 0);           // empty free
    send_req(REQ_FREE, 4095, 4096);     // free past the end
    send_req(REQ_ALLOC, 0, 3);          // cut short at chunk count
    send_req(REQ_FREE, 100, 50);
    send_req(REQ_ALLOC, 0, 4096);       // cut short by a used chunk
    send_req(REQ_FREE, 10, 1);
    send_req(REQ_FREE, 10, 1);          // already free
    send_req(REQ_ALLOC, 0, 1);
    send_req(REQ_FREE, 0, 4096);
    send_req(REQ_ALLOC, 0, 1);          // chunk 0 stays out of reach
    drain_results();
  endtask

  task automatic test_config_extremes();
    set_config(0, 0);                   // no chunks at all
    send_req(REQ_ALLOC, 0, 1);
    send_req(REQ_FREE, 0, 4096);
    drain_results();
    set_config(8191, 0);                // clamps to the map size
    send_req(REQ_ALLOC, 0, 4096);
    send_req(REQ_ALLOC, 0, 2);
    drain_results();
    set_config(4096, 4095);
    send_req(REQ_ALLOC, 0, 7);
    send_req(REQ_ALLOC, 0, 0);
    drain_results();
    set_config(10, 10);                 // search window empty
    send_req(REQ_ALLOC, 0, 1);
    drain_results();
    set_config(10, 12);
    send_req(REQ_ALLOC, 0, 1);
    drain_results();
  endtask

  task automatic test_backpressure();
    int unsigned k;
    set_config(256, 0);
    rx_hold_req = rx_hold_req + 1;
    tx_gapless = 1'b1;
    for (k = 0; k < 12; k++) begin
      if (k % 3 == 2)
        send_req(REQ_FREE, $urandom_range(0, 255), $urandom_range(0, 16));
      else
        send_req(REQ_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 20));
    end
    tx_gapless = 1'b0;
    drain_results();
  endtask

  task automatic test_random_phase(input int unsigned total, input int unsigned first,
                                   input int unsigned n_items);
    int unsigned k;
    int unsigned sel;
    int unsigned pick;
    int unsigned lim;
    int unsigned s;
    int unsigned c;
    run_t        r;
    set_config(total, first);
    lim = (total > MAX_CHUNKS) ? MAX_CHUNKS : total;
    for (k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 12);
        send_req(REQ_ALLOC, $urandom_range(0, 4095), c);
      end else if (sel < 85 && live_runs.size() != 0) begin
        // release a granted run, sometimes only a piece of it
        pick = $urandom_range(0, live_runs.size() - 1);
        r = live_runs[pick];
        live_runs.delete(pick);
        s = 32'(r.start);
        c = 32'(r.count);
        if ($urandom_range(0, 3) == 0) begin
          s = 32'(r.start) + $urandom_range(0, 32'(r.count) - 1);
          c = $urandom_range(1, 32'(r.start) + 32'(r.count) - s);
        end
        send_req(REQ_FREE, s, c);
      end else if (sel < 98) begin
        s = $urandom_range(0, 1) ? $urandom_range(0, lim) : $urandom_range(0, 4095);
        if (s > 4095) s = 4095;
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40);
        send_req(REQ_FREE, s, c);
      end else begin
        send_req(REQ_FREE, 0, 4096);
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_phase(64, 0, 160);
    test_random_phase(4096, 1, 200);
    test_random_phase(8191, 4000, 100);
    test_random_phase(200, 1, 160);
    test_random_phase(37, 30, 120);
    test_random_phase(1, 0, 60);
    test_random_phase(4096, 4095, 40);
    test_random_phase(4096, 1, 120);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bra_pkg.sv
rtl/core/bra_ram.sv
rtl/core/bra_ctrl.sv
rtl/core/bra_dp.sv
rtl/core/bitmap_run_allocator_core.sv
bench/tb.sv
